// ----- rtl/ols_pkg.sv -----
// ols_pkg: shared constants for the ordered list store
// operation and status codes, field widths and parameter defaults
// no dependencies
`timescale 1ns / 1ps

package ols_pkg;

    localparam int DEF_CAPACITY    = 16;
    localparam int DEF_VALUE_WIDTH = 32;

    localparam int OP_W  = 4;
    localparam int IN_W  = 32;
    localparam int POS_W = 8;
    localparam int RES_W = 32;
    localparam int ST_W  = 2;

    localparam logic [OP_W-1:0] OP_PUSH_FRONT = 4'd0;
    localparam logic [OP_W-1:0] OP_PUSH_BACK  = 4'd1;
    localparam logic [OP_W-1:0] OP_INSERT_AT  = 4'd2;
    localparam logic [OP_W-1:0] OP_POP_FRONT  = 4'd3;
    localparam logic [OP_W-1:0] OP_POP_BACK   = 4'd4;
    localparam logic [OP_W-1:0] OP_REMOVE_AT  = 4'd5;
    localparam logic [OP_W-1:0] OP_GET_AT     = 4'd6;
    localparam logic [OP_W-1:0] OP_INDEX_OF   = 4'd7;
    localparam logic [OP_W-1:0] OP_CONTAINS   = 4'd8;
    localparam logic [OP_W-1:0] OP_LENGTH     = 4'd9;

    localparam logic [ST_W-1:0] ST_OK   = 2'd0;
    localparam logic [ST_W-1:0] ST_MISS = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL = 2'd2;

endpackage

// ----- rtl/ols_ram.sv -----
// ols_ram: generic single write, single read port ram with registered read
// no dependencies
`timescale 1ns / 1ps

module ols_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/ordered_list_store.sv -----
// ordered_list_store: bounded ordered list of signed values kept in a ram, walked one entry per cycle
// depends on ols_pkg and ols_ram
// length, refused and missed words go from idle straight to done, where the result is registered
// remove, get, search: scan, drain, done; insert: scan and drain to shift (none on append), put, done
// throughput: one word at a time, the next word is taken the cycle after the result is registered
// reset: synchronous active low, clears the entry count and control, not the ram
`timescale 1ns / 1ps

module ordered_list_store #(
    parameter int CAPACITY    = ols_pkg::DEF_CAPACITY,
    parameter int VALUE_WIDTH = ols_pkg::DEF_VALUE_WIDTH,
    localparam int CW    = $clog2(CAPACITY + 1),
    localparam int IN_DW = ((ols_pkg::OP_W + ols_pkg::IN_W + ols_pkg::POS_W + 7) / 8) * 8,
    localparam int OUT_DW = ((ols_pkg::RES_W + ols_pkg::ST_W + CW + 7) / 8) * 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    // operation, element_value, position
    input  logic [IN_DW-1:0]  i_s_tdata,
    output logic              o_m_tvalid,
    input  logic              i_m_tready,
    // result_value, status, entry_count
    output logic [OUT_DW-1:0] o_m_tdata
);

    localparam int AW    = $clog2(CAPACITY);
    localparam int PW    = (CW > ols_pkg::POS_W) ? CW : ols_pkg::POS_W;
    localparam int VW    = VALUE_WIDTH;
    localparam int RW    = ols_pkg::RES_W;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_DRAIN = 3'd2;
    localparam logic [2:0] S_PUT   = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    logic [2:0]                  r_state, n_state;
    logic [ols_pkg::OP_W-1:0]    r_op, n_op;
    logic [VW-1:0]               r_val, n_val;
    logic [AW-1:0]               r_at, n_at;
    logic [AW-1:0]               r_addr, n_addr;
    logic [AW-1:0]               r_end, n_end;
    logic                        r_dn, n_dn;
    logic                        r_pv, n_pv;
    logic [AW-1:0]               r_paddr, n_paddr;
    logic [RW-1:0]               r_res, n_res;
    logic [ols_pkg::ST_W-1:0]    r_st, n_st;
    logic                        r_found, n_found;
    logic [CW-1:0]               r_count, n_count;
    logic                        r_out_valid, n_out_valid;
    logic [OUT_DW-1:0]           r_out_data, n_out_data;

    logic [ols_pkg::OP_W-1:0]    in_op;
    logic [ols_pkg::IN_W-1:0]    in_val;
    logic [ols_pkg::POS_W-1:0]   in_pos;
    logic [VW-1:0]               in_sv;
    logic [PW-1:0]               pos_x;
    logic [PW-1:0]               cnt_x;
    logic [AW-1:0]               cnt_a;
    logic [AW-1:0]               last_a;
    logic                        op_ins;
    logic                        op_rem;
    logic                        op_get;
    logic                        op_srch;

    logic                        ram_we;
    logic [AW-1:0]               ram_waddr;
    logic [VW-1:0]               ram_wdata;
    logic [AW-1:0]               ram_raddr;
    logic [VW-1:0]               ram_rdata;
    logic [RW-1:0]               rd_res;

    assign in_op  = i_s_tdata[ols_pkg::OP_W-1:0];
    assign in_val = i_s_tdata[ols_pkg::OP_W +: ols_pkg::IN_W];
    assign in_pos = i_s_tdata[ols_pkg::OP_W + ols_pkg::IN_W +: ols_pkg::POS_W];

    generate
        if (VW > ols_pkg::IN_W) begin : g_wide
            assign in_sv  = {{(VW - ols_pkg::IN_W){in_val[ols_pkg::IN_W-1]}}, in_val};
        end else begin : g_narrow
            assign in_sv  = in_val[VW-1:0];
        end
        if (VW >= RW) begin : g_res_wide
            assign rd_res = ram_rdata[RW-1:0];
        end else begin : g_res_narrow
            assign rd_res = {{(RW - VW){ram_rdata[VW-1]}}, ram_rdata};
        end
    endgenerate

    assign pos_x  = PW'(in_pos);
    assign cnt_x  = PW'(r_count);
    assign cnt_a  = r_count[AW-1:0];
    assign last_a = AW'(r_count - 1'b1);

    assign op_ins  = (r_op == ols_pkg::OP_PUSH_FRONT) || (r_op == ols_pkg::OP_PUSH_BACK) ||
                     (r_op == ols_pkg::OP_INSERT_AT);
    assign op_rem  = (r_op == ols_pkg::OP_POP_FRONT) || (r_op == ols_pkg::OP_POP_BACK) ||
                     (r_op == ols_pkg::OP_REMOVE_AT);
    assign op_get  = (r_op == ols_pkg::OP_GET_AT);
    assign op_srch = (r_op == ols_pkg::OP_INDEX_OF) || (r_op == ols_pkg::OP_CONTAINS);

    assign o_s_tready = (r_state == S_IDLE);

    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_val       = r_val;
        n_at        = r_at;
        n_addr      = r_addr;
        n_end       = r_end;
        n_dn        = r_dn;
        n_pv        = 1'b0;
        n_paddr     = r_paddr;
        n_res       = r_res;
        n_st        = r_st;
        n_found     = r_found;
        n_count     = r_count;
        n_out_valid = r_out_valid & ~i_m_tready;
        n_out_data  = r_out_data;
        ram_we      = 1'b0;
        ram_waddr   = r_paddr;
        ram_wdata   = ram_rdata;
        ram_raddr   = r_addr;

        // data of the read issued last cycle
        if (r_pv) begin
            if (op_ins) begin
                ram_we    = 1'b1;
                ram_waddr = AW'(r_paddr + 1'b1);
            end else if (op_rem) begin
                if (r_paddr == r_at) begin
                    n_res = rd_res;
                end else begin
                    ram_we    = 1'b1;
                    ram_waddr = AW'(r_paddr - 1'b1);
                end
            end else if (op_get) begin
                n_res = rd_res;
            end else if (op_srch) begin
                if (ram_rdata == r_val && !r_found) begin
                    n_found = 1'b1;
                    if (r_op == ols_pkg::OP_INDEX_OF) begin
                        n_res = RW'(r_paddr);
                    end
                end
            end
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    n_op    = in_op;
                    n_val   = in_sv;
                    n_res   = '0;
                    n_st    = ols_pkg::ST_OK;
                    n_found = 1'b0;
                    n_dn    = 1'b0;
                    n_state = S_DONE;
                    unique case (in_op)
                        ols_pkg::OP_PUSH_FRONT, ols_pkg::OP_PUSH_BACK,
                        ols_pkg::OP_INSERT_AT: begin
                            if (r_count >= CW'(CAPACITY)) begin
                                n_st = ols_pkg::ST_FULL;
                            end else begin
                                if (in_op == ols_pkg::OP_PUSH_FRONT) begin
                                    n_at = '0;
                                end else if (in_op == ols_pkg::OP_PUSH_BACK ||
                                             pos_x >= cnt_x) begin
                                    n_at = cnt_a;
                                end else begin
                                    n_at = AW'(in_pos);
                                end
                                n_addr = last_a;
                                n_end  = n_at;
                                n_dn   = 1'b1;
                                n_state = (n_at == cnt_a) ? S_PUT : S_SCAN;
                            end
                        end
                        ols_pkg::OP_POP_FRONT, ols_pkg::OP_POP_BACK,
                        ols_pkg::OP_REMOVE_AT: begin
                            if (r_count == '0) begin
                                n_st = ols_pkg::ST_MISS;
                            end else if (in_op == ols_pkg::OP_REMOVE_AT && pos_x >= cnt_x) begin
                                n_st = ols_pkg::ST_MISS;
                            end else begin
                                if (in_op == ols_pkg::OP_POP_FRONT) begin
                                    n_at = '0;
                                end else if (in_op == ols_pkg::OP_POP_BACK) begin
                                    n_at = last_a;
                                end else begin
                                    n_at = AW'(in_pos);
                                end
                                n_addr  = n_at;
                                n_end   = last_a;
                                n_state = S_SCAN;
                            end
                        end
                        ols_pkg::OP_GET_AT: begin
                            if (pos_x >= cnt_x) begin
                                n_st = ols_pkg::ST_MISS;
                            end else begin
                                n_addr  = AW'(in_pos);
                                n_end   = AW'(in_pos);
                                n_state = S_SCAN;
                            end
                        end
                        ols_pkg::OP_INDEX_OF, ols_pkg::OP_CONTAINS: begin
                            if (r_count == '0) begin
                                n_st = ols_pkg::ST_MISS;
                            end else begin
                                n_addr  = '0;
                                n_end   = last_a;
                                n_state = S_SCAN;
                            end
                        end
                        ols_pkg::OP_LENGTH: begin
                            n_res = RW'(r_count);
                        end
                        default: begin
                            n_st = ols_pkg::ST_MISS;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                ram_raddr = r_addr;
                n_pv      = 1'b1;
                n_paddr   = r_addr;
                if (r_addr == r_end) begin
                    n_state = S_DRAIN;
                end else if (r_dn) begin
                    n_addr = AW'(r_addr - 1'b1);
                end else begin
                    n_addr = AW'(r_addr + 1'b1);
                end
            end
            S_DRAIN: begin
                n_state = S_DONE;
                if (op_ins) begin
                    n_state = S_PUT;
                end else if (op_rem) begin
                    n_count = CW'(r_count - 1'b1);
                end else if (op_srch) begin
                    n_st = n_found ? ols_pkg::ST_OK : ols_pkg::ST_MISS;
                end
            end
            S_PUT: begin
                ram_we    = 1'b1;
                ram_waddr = r_at;
                ram_wdata = r_val;
                n_count   = CW'(r_count + 1'b1);
                n_state   = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || i_m_tready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = OUT_DW'({r_count, r_st, r_res});
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pv        <= 1'b0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pv        <= n_pv;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op       <= n_op;
        r_val      <= n_val;
        r_at       <= n_at;
        r_addr     <= n_addr;
        r_end      <= n_end;
        r_dn       <= n_dn;
        r_paddr    <= n_paddr;
        r_res      <= n_res;
        r_st       <= n_st;
        r_found    <= n_found;
        r_out_data <= n_out_data;
    end

    ols_ram #(
        .WIDTH (VW),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

    // count stays within capacity
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("entry count above capacity");

    // ram is only written while an item is at work
    a_no_idle_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !ram_we)
        else $error("ram write while idle");

    // walk never reads past the stored entries
    a_scan_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (CW'(r_addr) < r_count))
        else $error("walk address beyond stored entries");

    // a full status always goes out with a full store
    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_st == ols_pkg::ST_FULL) |-> (r_count == CW'(CAPACITY)))
        else $error("full status with room left");

    // an accepted word always moves the sequencer out of idle
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> (r_state != S_IDLE))
        else $error("accepted word left sequencer idle");

endmodule

// ----- sim/ordered_list_store_tb.sv -----
// ordered_list_store_tb: self-checking bench for the bounded ordered list store
// directed edge cases then random operation mixes under ready/valid backpressure
// depends on ols_pkg and ordered_list_store
`timescale 1ns / 1ps

module ordered_list_store_tb;

    localparam int CAPACITY = ols_pkg::DEF_CAPACITY;
    localparam int AW       = $clog2(CAPACITY);
    localparam int CW       = $clog2(CAPACITY + 1);
    localparam int OP_W     = ols_pkg::OP_W;
    localparam int IN_W     = ols_pkg::IN_W;
    localparam int POS_W    = ols_pkg::POS_W;
    localparam int RES_W    = ols_pkg::RES_W;
    localparam int ST_W     = ols_pkg::ST_W;
    localparam int IN_DW    = ((OP_W + IN_W + POS_W + 7) / 8) * 8;
    localparam int OUT_DW   = ((RES_W + ST_W + CW + 7) / 8) * 8;
    localparam logic [OP_W-1:0] OP_UNUSED_LO = 4'd10;
    localparam logic [OP_W-1:0] OP_UNUSED_HI = 4'd15;

    typedef struct packed {
        logic [CW-1:0]           count;
        logic [ST_W-1:0]         status;
        logic signed [RES_W-1:0] value;
    } list_result_t;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    // operation, element_value, position
    logic [IN_DW-1:0]  s_tdata = '0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    // result_value, status, entry_count
    logic [OUT_DW-1:0] m_tdata;

    // list contents as the block should hold them
    logic signed [IN_W-1:0] entry_vals [CAPACITY];
    logic [CW-1:0]          entry_len = '0;
    list_result_t           pending_results [$];

    int send_idle_pct = 11;
    int recv_idle_pct = 82;
    int n_errors  = 0;
    int n_sent    = 0;
    int n_checked = 0;
    int n_full    = 0;
    int n_miss    = 0;

    logic signed [IN_W-1:0] value_pool [6] = '{32'sh7FFFFFFF, 32'sh80000000, 32'sd0,
                                               -32'sd1, 32'sd42, -32'sd1000};

    ordered_list_store i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        m_tready <= ($urandom_range(99, 0) >= recv_idle_pct);
    end

    function automatic list_result_t predict_list_op(logic [OP_W-1:0] op,
                                                     logic signed [IN_W-1:0] val,
                                                     logic [POS_W-1:0] pos);
        list_result_t r;
        int           at;
        int           i;
        bit           hit;
        r.value  = '0;
        r.status = ols_pkg::ST_OK;
        case (op)
            ols_pkg::OP_PUSH_FRONT, ols_pkg::OP_PUSH_BACK, ols_pkg::OP_INSERT_AT: begin
                if (entry_len >= CAPACITY) begin
                    r.status = ols_pkg::ST_FULL;
                end else begin
                    at = (op == ols_pkg::OP_PUSH_FRONT) ? 0 :
                         (op == ols_pkg::OP_PUSH_BACK) ? int'(entry_len) : int'(pos);
                    if (at > entry_len)
                        at = int'(entry_len);
                    for (i = int'(entry_len); i > at; i--)
                        entry_vals[AW'(i)] = entry_vals[AW'(i - 1)];
                    entry_vals[AW'(at)] = val;
                    entry_len++;
                end
            end
            ols_pkg::OP_POP_FRONT, ols_pkg::OP_POP_BACK, ols_pkg::OP_REMOVE_AT: begin
                at = (op == ols_pkg::OP_POP_FRONT) ? 0 :
                     (op == ols_pkg::OP_POP_BACK) ? int'(entry_len) - 1 : int'(pos);
                if (entry_len == 0 || at >= entry_len) begin
                    r.status = ols_pkg::ST_MISS;
                end else begin
                    r.value = entry_vals[AW'(at)];
                    for (i = at; i + 1 < entry_len; i++)
                        entry_vals[AW'(i)] = entry_vals[AW'(i + 1)];
                    entry_len--;
                end
            end
            ols_pkg::OP_GET_AT: begin
                if (pos >= entry_len)
                    r.status = ols_pkg::ST_MISS;
                else
                    r.value = entry_vals[AW'(pos)];
            end
            ols_pkg::OP_INDEX_OF, ols_pkg::OP_CONTAINS: begin
                hit = 1'b0;
                for (i = 0; i < entry_len && !hit; i++) begin
                    if (entry_vals[AW'(i)] == val) begin
                        hit = 1'b1;
                        if (op == ols_pkg::OP_INDEX_OF)
                            r.value = i;
                    end
                end
                if (!hit)
                    r.status = ols_pkg::ST_MISS;
            end
            ols_pkg::OP_LENGTH: r.value = RES_W'(entry_len);
            default:   r.status = ols_pkg::ST_MISS;
        endcase
        r.count = entry_len;
        if (r.status == ols_pkg::ST_FULL)
            n_full++;
        if (r.status == ols_pkg::ST_MISS)
            n_miss++;
        return r;
    endfunction

    // leaves valid high after the accept so back-to-back words need no toggle
    task automatic send_word(logic [OP_W-1:0] op, logic signed [IN_W-1:0] val,
                             logic [POS_W-1:0] pos);
        while ($urandom_range(99, 0) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(IN_DW - OP_W - IN_W - POS_W){1'b0}}, pos, val, op};
        @(posedge i_clk);
        while (!s_tready)
            @(posedge i_clk);
        pending_results.push_back(predict_list_op(op, val, pos));
        n_sent++;
    endtask

    always @(posedge i_clk) begin
        list_result_t exp_r;
        list_result_t got_r;
        if (i_rst_n && m_tvalid && m_tready) begin
            got_r = m_tdata[RES_W+ST_W+CW-1:0];
            if (pending_results.size() == 0) begin
                if (n_errors < 10)
                    $display("%0t: unexpected result word value=%0d status=%0d count=%0d",
                             $realtime, got_r.value, got_r.status, got_r.count);
                n_errors++;
            end else begin
                exp_r = pending_results.pop_front();
                n_checked++;
                if (got_r.value !== exp_r.value || got_r.status !== exp_r.status ||
                    got_r.count !== exp_r.count) begin
                    if (n_errors < 10)
                        $display("%0t: mismatch exp value=%0d status=%0d count=%0d, %s%0d %s%0d %s%0d",
                                 $realtime, exp_r.value, exp_r.status, exp_r.count,
                                 "got value=", got_r.value, "status=", got_r.status,
                                 "count=", got_r.count);
                    n_errors++;
                end
            end
        end
    end

    task automatic test_empty_store();
        send_word(ols_pkg::OP_LENGTH, 32'sd0, 8'd0);
        send_word(ols_pkg::OP_POP_FRONT, 32'sd0, 8'd0);
        send_word(ols_pkg::OP_POP_BACK, 32'sd0, 8'd0);
        send_word(ols_pkg::OP_REMOVE_AT, 32'sd0, 8'd0);
        send_word(ols_pkg::OP_GET_AT, 32'sd0, 8'd0);
        send_word(ols_pkg::OP_INDEX_OF, 32'sd5, 8'd0);
        send_word(ols_pkg::OP_CONTAINS, 32'sd5, 8'd0);
    endtask

    task automatic test_insert_paths();
        send_word(ols_pkg::OP_PUSH_FRONT, 32'sh7FFFFFFF, 8'd0);
        send_word(ols_pkg::OP_PUSH_BACK, 32'sh80000000, 8'd0);
        // position far past the end appends
        send_word(ols_pkg::OP_INSERT_AT, 32'sd0, 8'd255);
        send_word(ols_pkg::OP_INSERT_AT, -32'sd1, 8'd1);
        send_word(ols_pkg::OP_INSERT_AT, 32'sh12345678, 8'd0);
    endtask

    task automatic test_read_and_search();
        send_word(ols_pkg::OP_GET_AT, 32'sd0, 8'd0);
        send_word(ols_pkg::OP_GET_AT, 32'sd0, 8'd5);
        send_word(ols_pkg::OP_GET_AT, 32'sd0, 8'd255);
        send_word(ols_pkg::OP_INDEX_OF, 32'sh80000000, 8'd0);
        send_word(ols_pkg::OP_INDEX_OF, 32'sh5555AAAA, 8'd0);
        send_word(ols_pkg::OP_CONTAINS, -32'sd1, 8'd0);
        send_word(ols_pkg::OP_CONTAINS, 32'sd1, 8'd0);
        send_word(ols_pkg::OP_LENGTH, 32'sd0, 8'd0);
    endtask

    task automatic test_remove_paths();
        send_word(ols_pkg::OP_REMOVE_AT, 32'sd0, 8'd255);
        send_word(ols_pkg::OP_REMOVE_AT, 32'sd0, 8'd2);
        send_word(ols_pkg::OP_POP_FRONT, 32'sd0, 8'd0);
        send_word(ols_pkg::OP_POP_BACK, 32'sd0, 8'd0);
    endtask

    task automatic test_undefined_ops();
        send_word(OP_UNUSED_LO, 32'sd0, 8'd0);
        send_word(OP_UNUSED_HI, -32'sd1, 8'd255);
    endtask

    task automatic test_full_store();
        while (entry_len < CAPACITY)
            send_word(ols_pkg::OP_PUSH_BACK, $urandom, 8'($urandom_range(255, 0)));
        send_word(ols_pkg::OP_PUSH_FRONT, 32'sd7, 8'd0);
        send_word(ols_pkg::OP_PUSH_BACK, 32'sd7, 8'd0);
        send_word(ols_pkg::OP_INSERT_AT, 32'sd7, 8'd3);
        send_word(ols_pkg::OP_GET_AT, 32'sd0, 8'(CAPACITY - 1));
        send_word(ols_pkg::OP_LENGTH, 32'sd0, 8'd0);
    endtask

    // drifts between filling and draining so both full and empty recur
    task automatic test_random_ops(int items, int send_pct, int recv_pct);
        logic [OP_W-1:0]        op;
        logic signed [IN_W-1:0] val;
        logic [POS_W-1:0]       pos;
        bit                     growing;
        int                     roll;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        growing = 1'b1;
        for (int k = 0; k < items; k++) begin
            if (k % 24 == 0)
                growing = ($urandom_range(1, 0) == 1);
            roll = $urandom_range(99, 0);
            if (roll < 3)
                op = OP_W'($urandom_range(OP_UNUSED_HI, OP_UNUSED_LO));
            else if (roll < (growing ? 63 : 23))
                op = OP_W'($urandom_range(ols_pkg::OP_INSERT_AT, ols_pkg::OP_PUSH_FRONT));
            else if (roll < 70)
                op = OP_W'($urandom_range(ols_pkg::OP_REMOVE_AT, ols_pkg::OP_POP_FRONT));
            else
                op = OP_W'($urandom_range(ols_pkg::OP_LENGTH, ols_pkg::OP_GET_AT));
            if ($urandom_range(9, 0) < 5)
                val = value_pool[$urandom_range(5, 0)];
            else
                val = $urandom;
            if ($urandom_range(9, 0) < 8)
                pos = POS_W'($urandom_range(entry_len + 1, 0));
            else
                pos = POS_W'($urandom_range(255, 0));
            send_word(op, val, pos);
        end
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_empty_store();
        test_insert_paths();
        test_read_and_search();
        test_remove_paths();
        test_undefined_ops();
        test_full_store();
        test_random_ops(400, 11, 82);
        test_random_ops(400, 82, 11);
        test_random_ops(400, 0, 0);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (CAPACITY + 8) @(posedge i_clk);
        $display("sent %0d words, checked %0d results", n_sent, n_checked);
        $display("refused as full %0d times, missed or out of range %0d times",
                 n_full, n_miss);
        if (n_errors == 0 && pending_results.size() == 0) begin
            $display("ordered_list_store_tb: clean");
        end else begin
            $display("ordered_list_store_tb: errors");
        end
        $finish;
    end

    initial begin
        #10ms;
        $display("ordered_list_store_tb: errors");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/ols_pkg.sv
rtl/ols_ram.sv
rtl/ordered_list_store.sv
sim/ordered_list_store_tb.sv
